### rtl/mpeg_video_picture_header_scanner_unit_macros.svh
// Assertion shorthands shared by the scanner RTL.
// All checks sample on the rising edge of clk and are muted during rst.
`ifndef MPEG_VIDEO_PICTURE_HEADER_SCANNER_UNIT_MACROS_SVH
`define MPEG_VIDEO_PICTURE_HEADER_SCANNER_UNIT_MACROS_SVH

// Same-cycle implication
`define MVPHS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define MVPHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mvphs_pkg.sv
package mvphs_pkg;

  // Start code detection
  localparam logic [23:0] CODE_PREFIX   = 24'h000001;
  localparam logic [7:0]  CODE_PICTURE  = 8'h00;
  localparam logic [7:0]  CODE_SEQUENCE = 8'hb3;
  localparam logic [31:0] WINDOW_IDLE   = 32'hffff_ffff;

  // Picture header byte tracker: next header byte to capture
  typedef enum logic [2:0] {
    HDR_IDLE = 3'd0,
    HDR_TREF = 3'd1,
    HDR_TYPE = 3'd2,
    HDR_VBV  = 3'd3,
    HDR_FWD  = 3'd4,
    HDR_BWD  = 3'd5
  } hdr_idx_t;

  // Picture coding types
  localparam logic [2:0] PIC_P = 3'd2;
  localparam logic [2:0] PIC_B = 3'd3;

  // Output beat width: 54 payload bits padded to whole bytes
  localparam int unsigned OUT_BITS  = 54;
  localparam int unsigned OUT_BYTES = (OUT_BITS + 7) / 8;

  // Vector field pair: full pel flag and f code
  typedef struct packed {
    logic       full_pel;
    logic [2:0] f_code;
  } vec_fields_t;

endpackage

### rtl/mpeg_video_picture_header_scanner_unit.sv
// Channel   Dir  Beat contents
// s_axis    in   tdata: data_byte[7:0]; tlast: last_byte
// m_axis    out  tdata: temporal_ref, picture_type, full_pel_forward,
//                forward_f_code, full_pel_backward, backward_f_code,
//                sequence_start, header_word, zero pad to 56 bits
//
// One byte is taken per cycle while s_axis_tready is high; the scan state
// (start code window, header byte tracker, picture fields) updates in the
// cycle the byte is taken. A tlast beat yields one registered result.
// s_axis_tready is low only while a result sits unread in the output register.
// rst is synchronous; after it the window is all ones and all fields are zero.
`include "mpeg_video_picture_header_scanner_unit_macros.svh"

module mpeg_video_picture_header_scanner_unit
  import mvphs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [7:0]               s_axis_tdata,  // [7:0] data_byte
  input  logic                     s_axis_tlast,  // last_byte
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // [9:0] temporal_ref, [12:10] picture_type, [13] full_pel_forward,
  // [16:14] forward_f_code, [17] full_pel_backward, [20:18] backward_f_code,
  // [21] sequence_start, [53:22] header_word, [55:54] zero
  output logic [OUT_BYTES*8-1:0]   m_axis_tdata
);

  // Scan state
  logic [31:0] window;
  hdr_idx_t    hdr_idx;
  logic [9:0]  tref;
  logic [2:0]  pic_type;
  vec_fields_t fwd;
  vec_fields_t bwd;
  logic        seq_seen;

  logic [31:0] window_next;
  hdr_idx_t    hdr_idx_next;
  logic [9:0]  tref_next;
  logic [2:0]  pic_type_next;
  vec_fields_t fwd_next;
  vec_fields_t bwd_next;
  logic        seq_seen_next;

  logic [OUT_BITS-1:0] result_next;
  logic [31:0]         hdr_word;
  logic [31:0]         shifted;
  logic [7:0]          b;
  logic                pb;
  logic                beat_in;
  logic                beat_out;

  assign b        = s_axis_tdata;
  assign beat_in  = s_axis_tvalid && s_axis_tready;
  assign beat_out = m_axis_tvalid && m_axis_tready;

  // Output register doubles as the skid stage
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;

  // Header capture then start code search
  always_comb begin
    pb            = (pic_type == PIC_P) || (pic_type == PIC_B);
    tref_next     = tref;
    pic_type_next = pic_type;
    fwd_next      = fwd;
    bwd_next      = bwd;
    seq_seen_next = seq_seen;
    hdr_idx_next  = hdr_idx;

    unique case (hdr_idx)
      HDR_IDLE: ;
      HDR_TREF: tref_next = {b, 2'b00};
      HDR_TYPE: begin
        tref_next     = {tref[9:2], b[7:6]};
        pic_type_next = b[5:3];
        fwd_next      = '0;
        bwd_next      = '0;
      end
      HDR_VBV: ;
      HDR_FWD: begin
        if (pb) fwd_next = '{full_pel: b[2], f_code: {b[1:0], 1'b0}};
      end
      HDR_BWD: begin
        if (pb) fwd_next.f_code[0] = b[7];
        if (pic_type == PIC_B) bwd_next = '{full_pel: b[6], f_code: b[5:3]};
      end
      default: ;
    endcase

    // Tracker steps through the five header bytes, then stops
    case (hdr_idx)
      HDR_IDLE: hdr_idx_next = HDR_IDLE;
      HDR_TREF: hdr_idx_next = HDR_TYPE;
      HDR_TYPE: hdr_idx_next = HDR_VBV;
      HDR_VBV:  hdr_idx_next = HDR_FWD;
      HDR_FWD:  hdr_idx_next = HDR_BWD;
      default:  hdr_idx_next = HDR_IDLE;
    endcase

    shifted     = {window[23:0], b};
    window_next = shifted;
    if (shifted[31:8] == CODE_PREFIX) begin
      if (b == CODE_PICTURE)  hdr_idx_next  = HDR_TREF;
      if (b == CODE_SEQUENCE) seq_seen_next = 1'b1;
      window_next = WINDOW_IDLE;
    end
  end

  // RFC 2250 video header word, T/AN/N/B/E zero
  assign hdr_word = {6'd0, tref_next, 2'b00, seq_seen_next, 2'b00, pic_type_next,
                     bwd_next.full_pel, bwd_next.f_code,
                     fwd_next.full_pel, fwd_next.f_code};

  assign result_next = {hdr_word, seq_seen_next,
                        bwd_next.f_code, bwd_next.full_pel,
                        fwd_next.f_code, fwd_next.full_pel,
                        pic_type_next, tref_next};

  // State and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window        <= WINDOW_IDLE;
      hdr_idx       <= HDR_IDLE;
      tref          <= '0;
      pic_type      <= '0;
      fwd           <= '0;
      bwd           <= '0;
      seq_seen      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // New result wins over the beat leaving in the same cycle
      if (beat_in && s_axis_tlast) m_axis_tvalid <= 1'b1;
      else if (beat_out)           m_axis_tvalid <= 1'b0;
      if (beat_in) begin
        if (s_axis_tlast) begin
          // Frame done: hand out the fields and start afresh
          window        <= WINDOW_IDLE;
          hdr_idx       <= HDR_IDLE;
          tref          <= '0;
          pic_type      <= '0;
          fwd           <= '0;
          bwd           <= '0;
          seq_seen      <= 1'b0;
        end else begin
          window   <= window_next;
          hdr_idx  <= hdr_idx_next;
          tref     <= tref_next;
          pic_type <= pic_type_next;
          fwd      <= fwd_next;
          bwd      <= bwd_next;
          seq_seen <= seq_seen_next;
        end
      end
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk) begin
    if (beat_in && s_axis_tlast) begin
      m_axis_tdata <= {{(OUT_BYTES*8-OUT_BITS){1'b0}}, result_next};
    end
  end

  // Checks
  `MVPHS_ASSERT_NEXT(a_last_gives_result, beat_in && s_axis_tlast, m_axis_tvalid,
    "last beat did not produce a result")
  `MVPHS_ASSERT_NEXT(a_last_clears_state, beat_in && s_axis_tlast,
    window == WINDOW_IDLE && hdr_idx == HDR_IDLE && !seq_seen,
    "scan state not cleared after frame end")
  `MVPHS_ASSERT_NEXT(a_no_spurious_result,
    !m_axis_tvalid && !(beat_in && s_axis_tlast), !m_axis_tvalid,
    "result raised without a last beat")
  `MVPHS_ASSERT_NOW(a_idx_range, 1'b1,
    hdr_idx == HDR_IDLE || hdr_idx == HDR_TREF || hdr_idx == HDR_TYPE ||
    hdr_idx == HDR_VBV || hdr_idx == HDR_FWD || hdr_idx == HDR_BWD,
    "header tracker out of range")

endmodule
